/* rtl/risa_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// risa_pkg: shared types for the record insertion sorter
// Word layouts, the stored entry format, and the fixed-point average.
// ---------------------------------------------------------------------------
package risa_pkg;

	localparam int MAX_RECORDS_DEF = 16;
	localparam int SCORE_W         = 7;
	localparam int SUM_W           = 9;
	localparam int NUM_W           = 5;
	localparam int MEAN_W          = 15;

	typedef struct packed {
		logic [SCORE_W-1:0] score_first;
		logic [SCORE_W-1:0] score_second;
		logic [SCORE_W-1:0] score_third;
		logic               final_record;
	} item_t;

	typedef struct packed {
		logic [NUM_W-1:0]   record_number;
		logic [SCORE_W-1:0] out_first;
		logic [SCORE_W-1:0] out_second;
		logic [SCORE_W-1:0] out_third;
		logic [MEAN_W-1:0]  mean_fixed;
		logic               run_end;
	} result_t;

	// one held record: number, three scores, sort key
	typedef struct packed {
		logic [NUM_W-1:0]   number;
		logic [SCORE_W-1:0] s1;
		logic [SCORE_W-1:0] s2;
		logic [SCORE_W-1:0] s3;
		logic [SUM_W-1:0]   sum;
	} entry_t;

	// per-cycle command to every cell of the chain
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

	// floor(sum*256/3) = 85*sum + floor(sum/3); sum/3 exact as (sum*171)>>9 for sum < 512
	function automatic logic [MEAN_W-1:0] mean_of(input logic [SUM_W-1:0] sum);
		logic [MEAN_W-1:0] whole;
		logic [16:0]       third;
		whole = MEAN_W'(sum) * MEAN_W'(85);
		third = 17'(sum) * 17'd171;
		return whole + MEAN_W'(third[16:9]);
	endfunction

endpackage
`default_nettype wire

/* rtl/risa_cell.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// risa_cell: one slot of the sorted insertion chain
// Holds one record; opens for a new key or takes its neighbor's record.
// ---------------------------------------------------------------------------
module risa_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  risa_pkg::cell_ctl_t ctl,
	input  risa_pkg::entry_t    new_entry,
	input  risa_pkg::entry_t    left_entry,
	input  wire                 left_valid,
	input  wire                 left_ins,
	input  risa_pkg::entry_t    right_entry,
	input  wire                 right_valid,
	output risa_pkg::entry_t    entry,
	output logic                valid,
	output logic                ins
);

	risa_pkg::entry_t entry_q;
	logic             valid_q;

	// strictly greater key or empty: this slot moves aside for the new record
	assign ins   = !valid_q || (entry_q.sum > new_entry.sum);
	assign entry = entry_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= right_valid;
		end else if (ctl.insert && ins) begin
			valid_q <= valid_q | left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= right_entry;
		end else if (ctl.insert && ins) begin
			entry_q <= left_ins ? left_entry : new_entry;
		end
	end

endmodule
`default_nettype wire

/* rtl/record_insertion_sort_by_average.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// record_insertion_sort_by_average: stable sorter of score records
// Chain of cells that keeps records ordered by score sum, emitted on demand.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: drive item and raise start; the word is taken at a rising
//   edge with start high and busy low. A record is placed as it is taken:
//   every cell compares its key with the new one in parallel and the chain
//   shifts right by one slot past the insertion point, so words may arrive
//   back to back while busy stays low.
//   Records are numbered from 1 in arrival order. Once the chain is full
//   (MAX_RECORDS held), further records are dropped and get no number.
//   A word with final_record set is placed like any other, then busy rises
//   on the next cycle and the chain shifts left once per cycle, emitting
//   one result word per held record in ascending average order, equal
//   averages in arrival order. Busy stays high until the head slot is
//   found empty; each result word is registered from the head slot.
//   Output channel: each result word sits on result for exactly one cycle
//   with strobe high; run_end marks the last word of the run. The receiver
//   cannot stall, so no back-pressure exists.
//   Reset clears all valid bits, the record count and the strobe; the
//   stored record fields themselves are not cleared.
// ---------------------------------------------------------------------------
module record_insertion_sort_by_average #(
	parameter int MAX_RECORDS = risa_pkg::MAX_RECORDS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  risa_pkg::item_t    item,
	output logic               busy,
	output logic               strobe,
	output risa_pkg::result_t  result
);

	localparam int CNT_W = $clog2(MAX_RECORDS + 1);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t                     state_q;
	logic [CNT_W-1:0]           count_q;
	risa_pkg::cell_ctl_t        ctl;
	risa_pkg::entry_t           new_entry;
	risa_pkg::entry_t           cell_entry [MAX_RECORDS];
	logic                       cell_valid [MAX_RECORDS];
	logic                       cell_ins   [MAX_RECORDS];
	logic                       accept;
	logic                       full;
	logic [risa_pkg::NUM_W-1:0] next_num;

	assign busy   = (state_q == ST_EMIT);
	assign accept = start && !busy;
	// last slot occupied means the chain is full
	assign full   = cell_valid[MAX_RECORDS-1];

	assign ctl.insert = accept && !full;
	assign ctl.shift  = busy;

	// number keeps the low bits of the arrival position
	assign next_num            = risa_pkg::NUM_W'(count_q + CNT_W'(1));
	assign new_entry.number    = next_num;
	assign new_entry.s1        = item.score_first;
	assign new_entry.s2        = item.score_second;
	assign new_entry.s3        = item.score_third;
	assign new_entry.sum       = risa_pkg::SUM_W'(item.score_first)
	                           + risa_pkg::SUM_W'(item.score_second)
	                           + risa_pkg::SUM_W'(item.score_third);

	// Build the chain: left feeds inserts, right feeds the emit shift.
	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		risa_pkg::entry_t left_entry;
		logic             left_valid;
		logic             left_ins;
		risa_pkg::entry_t right_entry;
		logic             right_valid;

		if (i == 0) begin : g_head
			assign left_entry = '0;
			assign left_valid = 1'b1;
			assign left_ins   = 1'b0;
		end else begin : g_body
			assign left_entry = cell_entry[i-1];
			assign left_valid = cell_valid[i-1];
			assign left_ins   = cell_ins[i-1];
		end

		if (i == MAX_RECORDS - 1) begin : g_tail
			assign right_entry = '0;
			assign right_valid = 1'b0;
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
			assign right_valid = cell_valid[i+1];
		end

		risa_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_entry   (new_entry),
			.left_entry  (left_entry),
			.left_valid  (left_valid),
			.left_ins    (left_ins),
			.right_entry (right_entry),
			.right_valid (right_valid),
			.entry       (cell_entry[i]),
			.valid       (cell_valid[i]),
			.ins         (cell_ins[i])
		);
	end

	// Count placed records; restart numbering after a final word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && item.final_record) begin
			count_q <= '0;
		end else if (ctl.insert) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Sequencer: during the emit phase, drain the head cell into the result register each cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strobe  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					strobe <= 1'b0;
					if (accept && item.final_record) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					strobe <= cell_valid[0];
					if (!cell_valid[0]) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					strobe  <= 1'b0;
				end
			endcase
		end
	end

	// result payload: head record plus its fixed-point average
	always_ff @(posedge clk) begin
		if (busy) begin
			result.record_number <= cell_entry[0].number;
			result.out_first     <= cell_entry[0].s1;
			result.out_second    <= cell_entry[0].s2;
			result.out_third     <= cell_entry[0].s3;
			result.mean_fixed    <= risa_pkg::mean_of(cell_entry[0].sum);
			result.run_end       <= !cell_valid[1];
		end
	end

	// a result word only appears while the run drains
	a_strobe_busy : assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result strobe outside emit phase");

	// nothing follows the word marked as the end of the run
	a_run_end_last : assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.run_end) |=> !strobe)
		else $error("result word after run end");

	// an accepted final word always starts an emit run
	a_final_emits : assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.final_record) |=> (busy && count_q == '0))
		else $error("final word did not start emit");

	// chain fills from the head: the second slot is never held while the head is empty
	a_chain_packed : assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[1] |-> cell_valid[0])
		else $error("chain has a hole at the head");

endmodule
`default_nettype wire
